// ===== rtl/nearest_polygon_edge_to_point_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest polygon edge unit
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POLYGON_EDGE_TO_POINT_UNIT_ASSERT_SVH
`define NEAREST_POLYGON_EDGE_TO_POINT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// ante holds -> cons holds in the same cycle
`define NPE_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npe: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define NPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npe: next-cycle check failed");

`else

`define NPE_ASSERT(label, clk, rst_n, ante, cons)
`define NPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/npe_pkg.sv =====
// ----------------------------------------------------------------------------
// npe_pkg
// Widths, types and request structs shared by the nearest edge unit.
// ----------------------------------------------------------------------------
`default_nettype none

package npe_pkg;

    localparam int COORD_BITS  = 20;
    localparam int INDEX_BITS  = 12;
    localparam int T_FRAC_BITS = 16;

    // segment deltas and query offsets
    localparam int DELTA_BITS = COORD_BITS + 1;
    // serial multiplier operand must hold a delta and the clamped t as signed
    localparam int MUL_BITS = (DELTA_BITS > T_FRAC_BITS + 2) ? DELTA_BITS : T_FRAC_BITS + 2;
    localparam int ACC_BITS = DELTA_BITS + MUL_BITS + 1;
    localparam int LEN_BITS = 2 * DELTA_BITS;
    localparam int DIST_BITS = 2 * COORD_BITS + 4;
    localparam int T_BITS = T_FRAC_BITS + 1;
    localparam int MUL_CNT_BITS = $clog2(MUL_BITS + 1);
    localparam int DIV_CNT_BITS = $clog2(T_FRAC_BITS + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [INDEX_BITS-1:0] t_index;
    typedef logic signed [DELTA_BITS-1:0] t_delta;
    typedef logic signed [MUL_BITS-1:0]   t_mul;
    typedef logic signed [ACC_BITS-1:0]   t_acc;
    typedef logic        [LEN_BITS-1:0]   t_len;
    typedef logic        [DIST_BITS-1:0]  t_dist;
    typedef logic        [T_BITS-1:0]     t_tval;
    typedef logic        [T_FRAC_BITS-1:0] t_tfrac;

    localparam t_tval T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam t_acc  T_HALF = {{(ACC_BITS - T_FRAC_BITS){1'b0}},
                                1'b1, {(T_FRAC_BITS - 1){1'b0}}};

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_index id;
    } t_vertex;

    // request to a serial multiply-accumulate: a1*b1 + a2*b2
    typedef struct packed {
        logic   start;
        t_delta a1;
        t_mul   b1;
        t_delta a2;
        t_mul   b2;
    } t_mac_req;

    // request to the fraction divider: num / den, num < den
    typedef struct packed {
        logic start;
        t_len num;
        t_len den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/npe_ifs.sv =====
// ----------------------------------------------------------------------------
// npe item channels
// Valid/ready channels for vertex items in and nearest-edge results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface npe_in_if;
    logic            valid;
    logic            ready;
    npe_pkg::t_coord query_x;
    npe_pkg::t_coord query_y;
    npe_pkg::t_coord vert_x;
    npe_pkg::t_coord vert_y;
    npe_pkg::t_index vert_id;
    logic            last;

    modport source (output valid, query_x, query_y, vert_x, vert_y, vert_id, last,
                    input ready);
    modport sink   (input valid, query_x, query_y, vert_x, vert_y, vert_id, last,
                    output ready);
endinterface

interface npe_out_if;
    logic            valid;
    logic            ready;
    npe_pkg::t_index nearest_vertex;
    npe_pkg::t_coord proj_x;
    npe_pkg::t_coord proj_y;

    modport source (output valid, nearest_vertex, proj_x, proj_y, input ready);
    modport sink   (input valid, nearest_vertex, proj_x, proj_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/npe_mac.sv =====
// ----------------------------------------------------------------------------
// npe_mac
// Bit-serial signed multiply-accumulate, a1*b1 + a2*b2, multiplier MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_polygon_edge_to_point_unit_assert.svh"

module npe_mac (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire npe_pkg::t_mac_req i_req,
    output logic                   o_done,
    output npe_pkg::t_acc          o_acc
);

    logic                             r_busy;
    logic                             r_done;
    logic                             r_first;
    logic [npe_pkg::MUL_CNT_BITS-1:0] r_cnt;
    npe_pkg::t_delta                  r_a1;
    npe_pkg::t_delta                  r_a2;
    npe_pkg::t_mul                    r_b1;
    npe_pkg::t_mul                    r_b2;
    npe_pkg::t_acc                    r_acc;

    npe_pkg::t_acc pp1;
    npe_pkg::t_acc pp2;
    npe_pkg::t_acc pp_sum;
    npe_pkg::t_acc n_acc;

    // sign bit of the multiplier carries negative weight
    always_comb begin
        pp1    = r_b1[npe_pkg::MUL_BITS-1] ? npe_pkg::t_acc'(r_a1) : '0;
        pp2    = r_b2[npe_pkg::MUL_BITS-1] ? npe_pkg::t_acc'(r_a2) : '0;
        pp_sum = pp1 + pp2;
        n_acc  = (r_acc <<< 1) + (r_first ? (npe_pkg::t_acc'(0) - pp_sum) : pp_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= npe_pkg::MUL_CNT_BITS'(npe_pkg::MUL_BITS);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == npe_pkg::MUL_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a1  <= i_req.a1;
            r_a2  <= i_req.a2;
            r_b1  <= i_req.b1;
            r_b2  <= i_req.b2;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b1  <= r_b1 << 1;
            r_b2  <= r_b2 << 1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

    `NPE_ASSERT(a_mac_start_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `NPE_ASSERT(a_mac_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `NPE_ASSERT(a_mac_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

`default_nettype wire

// ===== rtl/npe_div.sv =====
// ----------------------------------------------------------------------------
// npe_div
// Restoring radix-2 divider giving the fraction num/den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_polygon_edge_to_point_unit_assert.svh"

module npe_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire npe_pkg::t_div_req i_req,
    output logic                   o_done,
    output npe_pkg::t_tfrac        o_quot
);

    logic                             r_busy;
    logic                             r_done;
    logic [npe_pkg::DIV_CNT_BITS-1:0] r_cnt;
    npe_pkg::t_len                    r_rem;
    npe_pkg::t_len                    r_den;
    npe_pkg::t_tfrac                  r_q;

    logic [npe_pkg::LEN_BITS:0]   sh;
    logic [npe_pkg::LEN_BITS+1:0] diff;
    logic                         ge;

    always_comb begin
        sh   = {r_rem, 1'b0};
        diff = {1'b0, sh} - {2'b00, r_den};
        ge   = !diff[npe_pkg::LEN_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= npe_pkg::DIV_CNT_BITS'(npe_pkg::T_FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == npe_pkg::DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it keeps LEN_BITS bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[npe_pkg::LEN_BITS-1:0] : sh[npe_pkg::LEN_BITS-1:0];
            r_q   <= {r_q[npe_pkg::T_FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `NPE_ASSERT(a_div_start_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `NPE_ASSERT(a_div_num_below, i_clk, i_rst_n, i_req.start, i_req.num < i_req.den)
    `NPE_ASSERT(a_div_rem_below, i_clk, i_rst_n, r_busy, r_rem < r_den)

endmodule

`default_nettype wire

// ===== rtl/nearest_polygon_edge_to_point_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_polygon_edge_to_point_unit: nearest polygon edge to a query point
// Items are taken one at a time: the input is not ready again until the item's
// segments are done. A last item also runs the closing segment and loads the
// result register, which waits while a pending result is not taken. A first
// vertex that is not last is only stored. The serial multiply passes and the
// divider (skipped when t clamps) set the rate.
// Reset (synchronous, active low) clears control; best distance goes to all ones.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_polygon_edge_to_point_unit_assert.svh"

module nearest_polygon_edge_to_point_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    npe_in_if.sink    i_item,
    npe_out_if.source o_result
);

    // Sequencer for one segment a -> b:
    //   LOAD   form deltas d = b - a and query offset u = q - a
    //   DOT    serial passes give dot = u.d and len2 = d.d in parallel
    //   CHK    clamp t to zero or one, or start the fraction divider
    //   PRJ    serial passes give t*dx and t*dy, then round onto a
    //   RND    form the error e = q - proj
    //   DST    serial pass gives e.e, then keep the segment if strictly nearer
    // The closing segment (last vertex back to the first) runs as a second
    // pass with r_phase set, and the result is then moved to the output register.
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LOAD  = 12'b000000000010,
        S_DOTGO = 12'b000000000100,
        S_DOT   = 12'b000000001000,
        S_CHK   = 12'b000000010000,
        S_DIV   = 12'b000000100000,
        S_PRJGO = 12'b000001000000,
        S_PRJ   = 12'b000010000000,
        S_RND   = 12'b000100000000,
        S_DSTGO = 12'b001000000000,
        S_DST   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    // control
    t_state r_state, n_state;
    logic   r_have_first, n_have_first;
    logic   r_phase, n_phase;
    logic   r_last, n_last;
    logic   r_out_valid, n_out_valid;

    // item and segment payload
    npe_pkg::t_coord  r_qx, n_qx;
    npe_pkg::t_coord  r_qy, n_qy;
    npe_pkg::t_vertex r_first, n_first;
    npe_pkg::t_vertex r_prev, n_prev;
    npe_pkg::t_vertex r_cur, n_cur;
    npe_pkg::t_coord  r_ax, n_ax;
    npe_pkg::t_index  r_aid, n_aid;
    npe_pkg::t_delta  r_dx, n_dx;
    npe_pkg::t_delta  r_dy, n_dy;
    npe_pkg::t_delta  r_ux, n_ux;
    npe_pkg::t_delta  r_uy, n_uy;
    npe_pkg::t_acc    r_dot, n_dot;
    npe_pkg::t_acc    r_len, n_len;
    npe_pkg::t_tval   r_t, n_t;
    npe_pkg::t_coord  r_ay, n_ay;
    npe_pkg::t_coord  r_px, n_px;
    npe_pkg::t_coord  r_py, n_py;

    // running best and output register
    npe_pkg::t_dist   r_best_dist, n_best_dist;
    npe_pkg::t_index  r_best_id, n_best_id;
    npe_pkg::t_coord  r_best_px, n_best_px;
    npe_pkg::t_coord  r_best_py, n_best_py;
    npe_pkg::t_index  r_out_id, n_out_id;
    npe_pkg::t_coord  r_out_px, n_out_px;
    npe_pkg::t_coord  r_out_py, n_out_py;

    // serial units
    npe_pkg::t_mac_req m0_req;
    npe_pkg::t_mac_req m1_req;
    npe_pkg::t_div_req div_req;
    logic              m0_done;
    logic              m1_done;
    npe_pkg::t_acc     m0_acc;
    npe_pkg::t_acc     m1_acc;
    logic              div_done;
    npe_pkg::t_tfrac   div_quot;

    npe_mac u_mac0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (m0_req),
        .o_done  (m0_done),
        .o_acc   (m0_acc)
    );

    npe_mac u_mac1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (m1_req),
        .o_done  (m1_done),
        .o_acc   (m1_acc)
    );

    npe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic             in_accept;
    logic             out_load;
    npe_pkg::t_vertex in_vtx;
    npe_pkg::t_vertex seg_a;
    npe_pkg::t_vertex seg_b;
    npe_pkg::t_acc    rnd_x;
    npe_pkg::t_acc    rnd_y;
    npe_pkg::t_dist   d2;

    assign in_accept = i_item.valid && i_item.ready;
    assign in_vtx    = '{x: i_item.vert_x, y: i_item.vert_y, id: i_item.vert_id};

    // open segment runs prev -> cur, closing segment cur -> first
    assign seg_a = r_phase ? r_cur : r_prev;
    assign seg_b = r_phase ? r_first : r_cur;

    // round half up: floor((t*d + half) / 2^T_FRAC_BITS)
    assign rnd_x = (m0_acc + npe_pkg::T_HALF) >>> npe_pkg::T_FRAC_BITS;
    assign rnd_y = (m1_acc + npe_pkg::T_HALF) >>> npe_pkg::T_FRAC_BITS;
    assign d2    = npe_pkg::t_dist'(m0_acc);

    // hold a pending result until taken, then free the register
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    // serial unit requests, operands latched by the units on start
    always_comb begin
        m0_req  = '{start: 1'b0, a1: r_ux, b1: npe_pkg::t_mul'(r_dx),
                    a2: r_uy, b2: npe_pkg::t_mul'(r_dy)};
        m1_req  = '{start: 1'b0, a1: r_dx, b1: npe_pkg::t_mul'(r_dx),
                    a2: r_dy, b2: npe_pkg::t_mul'(r_dy)};
        div_req = '{start: 1'b0, num: npe_pkg::t_len'(r_dot), den: npe_pkg::t_len'(r_len)};
        case (r_state)
            S_DOTGO: begin
                m0_req.start = 1'b1;
                m1_req.start = 1'b1;
            end
            S_PRJGO: begin
                m0_req = '{start: 1'b1, a1: r_dx, b1: npe_pkg::t_mul'(r_t),
                           a2: '0, b2: '0};
                m1_req = '{start: 1'b1, a1: r_dy, b1: npe_pkg::t_mul'(r_t),
                           a2: '0, b2: '0};
            end
            S_DSTGO: begin
                m0_req = '{start: 1'b1, a1: r_ux, b1: npe_pkg::t_mul'(r_ux),
                           a2: r_uy, b2: npe_pkg::t_mul'(r_uy)};
            end
            S_CHK: begin
                div_req.start = (r_dot > 0) && (r_dot < r_len);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_have_first = r_have_first;
        n_phase      = r_phase;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_first      = r_first;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_aid        = r_aid;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_ux         = r_ux;
        n_uy         = r_uy;
        n_dot        = r_dot;
        n_len        = r_len;
        n_t          = r_t;
        n_px         = r_px;
        n_py         = r_py;
        n_best_dist  = r_best_dist;
        n_best_id    = r_best_id;
        n_best_px    = r_best_px;
        n_best_py    = r_best_py;
        n_out_id     = r_out_id;
        n_out_px     = r_out_px;
        n_out_py     = r_out_py;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_qx   = i_item.query_x;
                    n_qy   = i_item.query_y;
                    n_cur  = in_vtx;
                    n_last = i_item.last;
                    if (!r_have_first) begin
                        // first vertex: store it; a segment runs now only if it is also last
                        n_have_first = 1'b1;
                        n_first      = in_vtx;
                        n_prev       = in_vtx;
                        if (i_item.last) begin
                            n_phase = 1'b1;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_phase = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_ax    = seg_a.x;
                n_ay    = seg_a.y;
                n_aid   = seg_a.id;
                n_dx    = npe_pkg::t_delta'($signed(seg_b.x)) -
                          npe_pkg::t_delta'($signed(seg_a.x));
                n_dy    = npe_pkg::t_delta'($signed(seg_b.y)) -
                          npe_pkg::t_delta'($signed(seg_a.y));
                n_ux    = npe_pkg::t_delta'(r_qx) - npe_pkg::t_delta'($signed(seg_a.x));
                n_uy    = npe_pkg::t_delta'(r_qy) - npe_pkg::t_delta'($signed(seg_a.y));
                n_state = S_DOTGO;
            end
            S_DOTGO: begin
                n_state = S_DOT;
            end
            S_DOT: begin
                if (m0_done) begin
                    n_dot   = m0_acc;
                    n_len   = m1_acc;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // zero-length segments land in the first arm (dot is zero)
                if (r_dot <= 0) begin
                    n_t     = '0;
                    n_state = S_PRJGO;
                end else if (r_dot >= r_len) begin
                    n_t     = npe_pkg::T_ONE;
                    n_state = S_PRJGO;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_t     = {1'b0, div_quot};
                    n_state = S_PRJGO;
                end
            end
            S_PRJGO: begin
                n_state = S_PRJ;
            end
            S_PRJ: begin
                if (m0_done) begin
                    n_px    = npe_pkg::t_coord'(rnd_x + npe_pkg::t_acc'(r_ax));
                    n_py    = npe_pkg::t_coord'(rnd_y + npe_pkg::t_acc'(r_ay));
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_ux    = npe_pkg::t_delta'(r_qx) - npe_pkg::t_delta'(r_px);
                n_uy    = npe_pkg::t_delta'(r_qy) - npe_pkg::t_delta'(r_py);
                n_state = S_DSTGO;
            end
            S_DSTGO: begin
                n_state = S_DST;
            end
            S_DST: begin
                if (m0_done) begin
                    // strict compare: the earlier segment keeps a tie
                    if (d2 < r_best_dist) begin
                        n_best_dist = d2;
                        n_best_id   = r_aid;
                        n_best_px   = r_px;
                        n_best_py   = r_py;
                    end
                    if (!r_phase) begin
                        n_prev = r_cur;
                        if (r_last) begin
                            n_phase = 1'b1;
                            n_state = S_LOAD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_best_id;
                    n_out_px     = r_best_px;
                    n_out_py     = r_best_py;
                    // drop the polygon state ready for the next one
                    n_best_dist  = '1;
                    n_best_id    = '0;
                    n_best_px    = '0;
                    n_best_py    = '0;
                    n_have_first = 1'b0;
                    n_phase      = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and running best, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_first <= 1'b0;
            r_phase      <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_best_dist  <= '1;
            r_best_id    <= '0;
            r_best_px    <= '0;
            r_best_py    <= '0;
        end else begin
            r_state      <= n_state;
            r_have_first <= n_have_first;
            r_phase      <= n_phase;
            r_last       <= n_last;
            r_out_valid  <= n_out_valid;
            r_best_dist  <= n_best_dist;
            r_best_id    <= n_best_id;
            r_best_px    <= n_best_px;
            r_best_py    <= n_best_py;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_first  <= n_first;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_aid    <= n_aid;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_ux     <= n_ux;
        r_uy     <= n_uy;
        r_dot    <= n_dot;
        r_len    <= n_len;
        r_t      <= n_t;
        r_px     <= n_px;
        r_py     <= n_py;
        r_out_id <= n_out_id;
        r_out_px <= n_out_px;
        r_out_py <= n_out_py;
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.nearest_vertex = r_out_id;
    assign o_result.proj_x         = r_out_px;
    assign o_result.proj_y         = r_out_py;

    // both multiply units run in lockstep on the paired passes
    `NPE_ASSERT(a_mac_lockstep, i_clk, i_rst_n, (r_state == S_DOT) || (r_state == S_PRJ), m0_done == m1_done)
    `NPE_ASSERT(a_t_clamped, i_clk, i_rst_n, r_state == S_PRJGO, r_t <= npe_pkg::T_ONE)
    `NPE_ASSERT(a_fresh_best, i_clk, i_rst_n, (r_state == S_IDLE) && !r_have_first, r_best_dist == '1)
    `NPE_ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, out_load, !r_have_first && r_out_valid)

endmodule

`default_nettype wire
